// ===== hw/rtl/bce_pkg.sv =====
// Shared types and constants for the Bezier curve evaluator.
// No dependencies; imported by bce_tdiv, bezier_curve_evaluator_unit and bce_checker.
package bce_pkg;

  localparam int COORD_W  = 24;  // control point / curve coordinate
  localparam int SAMPLE_W = 16;  // sample index and sample count
  localparam int CC_W     = 5;   // control count register
  localparam int T_W      = 17;  // t in Q16, 0 .. 1.0 inclusive
  localparam int Q30_W    = 31;  // powers, weights, blends in Q30, 0 .. 1.0
  localparam int CFG_IDX_W = 1;

  localparam logic [T_W-1:0]   T_ONE    = T_W'(65536);
  localparam logic [Q30_W-1:0] ONE_Q30  = Q30_W'(1 << 30);

  localparam logic [COORD_W-1:0] COORD_MAX_V = 24'h7F_FFFF;
  localparam logic [COORD_W-1:0] COORD_MIN_V = 24'h80_0000;
  localparam int COORD_POS_LIM = 8388607;
  localparam int COORD_NEG_LIM = 8388608;

  // input item kinds
  localparam logic ACTION_LOAD = 1'b0;
  localparam logic ACTION_EVAL = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CONTROL_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_COUNT  = 1'b1;

  localparam logic [CC_W-1:0]     CC_RESET = CC_W'(6);
  localparam logic [SAMPLE_W-1:0] SC_RESET = SAMPLE_W'(1000);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PREP,   // t division and Pascal row
    ST_POWT,   // t power multiply
    ST_POWU,   // round t power, u power multiply
    ST_POWR,   // round u power
    ST_WGT,    // t^k * u^(n-k)
    ST_WRND,
    ST_BIN,    // C(n,k) * w
    ST_BSAT,
    ST_MX,
    ST_MY,
    ST_MZ,
    ST_ACCZ,
    ST_FIN,    // magnitude of sums
    ST_RND     // round, saturate, load output register
  } bce_state_t;

endpackage

// ===== hw/rtl/bce_tdiv.sv =====
// Restoring divider forming t = floor(i * 2^16 / count), one bit a cycle.
// Depends on bce_pkg.
module bce_tdiv import bce_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [SAMPLE_W-1:0] dividend,
  input  logic [SAMPLE_W-1:0] divisor,
  output logic                busy,
  output logic [T_W-1:0]      t
);

  localparam int CNT_W = $clog2(SAMPLE_W + 1);

  logic                busy_r;
  logic [CNT_W-1:0]    cnt_r;
  logic [SAMPLE_W-1:0] rem_r;
  logic [SAMPLE_W-1:0] div_r;
  logic [T_W-1:0]      q_r;

  logic [SAMPLE_W:0]   rem2;
  logic [SAMPLE_W:0]   diff;
  logic                ge;

  assign rem2 = {rem_r, 1'b0};
  assign diff = rem2 - {1'b0, div_r};
  assign ge   = (rem2 >= {1'b0, div_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      // t is exactly one when the index reaches or runs past the count or count is zero
      busy_r <= !((divisor == '0) || (dividend >= divisor));
      cnt_r  <= CNT_W'(SAMPLE_W);
    end else if (busy_r) begin
      cnt_r <= cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= dividend;
      div_r <= divisor;
      q_r   <= ((divisor == '0) || (dividend >= divisor)) ? T_ONE : '0;
    end else if (busy_r) begin
      if (ge) begin
        rem_r <= diff[SAMPLE_W-1:0];
      end else begin
        rem_r <= rem2[SAMPLE_W-1:0];
      end
      q_r <= {q_r[T_W-2:0], ge};
    end
  end

  assign busy = busy_r;
  assign t    = q_r;

endmodule

// ===== hw/rtl/bezier_curve_evaluator_unit.sv =====
// Bezier curve evaluator, Bernstein form, with one shared 32x32 multiplier.
// Depends on bce_pkg and bce_tdiv.
//
//   channel | dir | handshake              | beat carries
//   in_     | in  | in_valid / in_ready    | action, point_index, point x/y/z, sample_index
//   out_    | out | out_valid / out_ready  | curve x/y/z
//   cfg_    | in  | cfg_we (no wait)       | cfg_index, cfg_wdata
//
// A load beat writes the point store in the accept cycle and the block stays ready.
// An evaluate beat runs the 16-step t divider beside the Pascal row build, then
// POWT, POWU and POWR for each power of t and u, then WGT, WRND, BIN, BSAT, MX, MY,
// MZ and ACCZ per control point, all through the single multiplier and its product
// register. A sample at or past the end skips the divider. in_ready is high only
// while the sequencer idles; the output register lets one result wait while the
// next sample is computed, the sequencer stalls at the final rounding step if the
// previous result was still not taken. rst_n is synchronous; the point store has
// no reset; the user keeps it read only after written, the block does not enforce it.
module bezier_curve_evaluator_unit import bce_pkg::*; #(
  parameter int MAX_POINTS = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  // input channel
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      in_action,
  input  logic [3:0]                in_point_index,
  input  logic signed [COORD_W-1:0] in_point_x,
  input  logic signed [COORD_W-1:0] in_point_y,
  input  logic signed [COORD_W-1:0] in_point_z,
  input  logic [SAMPLE_W-1:0]       in_sample_index,
  // result channel
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic signed [COORD_W-1:0] out_curve_x,
  output logic signed [COORD_W-1:0] out_curve_y,
  output logic signed [COORD_W-1:0] out_curve_z,
  // configuration
  input  logic                      cfg_we,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [SAMPLE_W-1:0]       cfg_wdata
);

  localparam int IDX_W  = $clog2(MAX_POINTS);
  localparam int BIN_W  = MAX_POINTS - 1;            // C(n,k) < 2^n
  localparam int ACC_W  = COORD_W + Q30_W + $clog2(MAX_POINTS) + 1;
  localparam int SUM_W  = ACC_W + 1;
  localparam int RND_W  = ACC_W - 29;
  localparam int PT_W   = 3 * COORD_W;
  localparam int LANE_X = 0;
  localparam int LANE_Y = 1;
  localparam int LANE_Z = 2;

  // ---------------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------------
  logic [CC_W-1:0]     cc_r;
  logic [SAMPLE_W-1:0] sc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cc_r <= CC_RESET;
      sc_r <= SC_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_CONTROL_COUNT: cc_r <= cfg_wdata[CC_W-1:0];
        CFG_SAMPLE_COUNT:  sc_r <= cfg_wdata;
        default:           ;
      endcase
    end
  end

  // degree: count clamped to 1 .. MAX_POINTS, minus one
  logic [IDX_W-1:0] n_c;
  always_comb begin
    if (cc_r == '0) begin
      n_c = '0;
    end else if (int'(cc_r) > MAX_POINTS) begin
      n_c = IDX_W'(MAX_POINTS - 1);
    end else begin
      n_c = IDX_W'(cc_r - CC_W'(1));
    end
  end

  // ---------------------------------------------------------------------------
  // handshake and sequencer
  // ---------------------------------------------------------------------------
  bce_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  logic in_acc, eval_acc, load_acc, out_free, div_busy, out_load;

  logic [IDX_W-1:0] n_r;
  logic [IDX_W-1:0] k_r;
  logic [IDX_W-1:0] nk_r;
  logic [IDX_W-1:0] pas_cnt_r;

  assign in_ready = (state_r == ST_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign eval_acc = in_acc && (in_action == ACTION_EVAL);
  assign load_acc = in_acc && (in_action == ACTION_LOAD);
  assign out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    out_load      = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      ST_IDLE:  if (eval_acc) state_nxt = ST_PREP;
      ST_PREP: begin
        if (!div_busy && (pas_cnt_r == '0)) begin
          state_nxt = (n_r == '0) ? ST_WGT : ST_POWT;
        end
      end
      ST_POWT:  state_nxt = ST_POWU;
      ST_POWU:  state_nxt = ST_POWR;
      ST_POWR:  state_nxt = (k_r == n_r) ? ST_WGT : ST_POWT;
      ST_WGT:   state_nxt = ST_WRND;
      ST_WRND:  state_nxt = ST_BIN;
      ST_BIN:   state_nxt = ST_BSAT;
      ST_BSAT:  state_nxt = ST_MX;
      ST_MX:    state_nxt = ST_MY;
      ST_MY:    state_nxt = ST_MZ;
      ST_MZ:    state_nxt = ST_ACCZ;
      ST_ACCZ:  state_nxt = (k_r == n_r) ? ST_FIN : ST_WGT;
      ST_FIN:   state_nxt = ST_RND;
      ST_RND: begin
        if (out_free) begin
          out_load      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // t divider
  // ---------------------------------------------------------------------------
  logic [T_W-1:0] div_t;

  bce_tdiv u_tdiv (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (eval_acc),
    .dividend (in_sample_index),
    .divisor  (sc_r),
    .busy     (div_busy),
    .t        (div_t)
  );

  // ---------------------------------------------------------------------------
  // point store: one write port (load beats), one registered read port
  // ---------------------------------------------------------------------------
  logic [PT_W-1:0] pstore_mem [MAX_POINTS];
  logic [PT_W-1:0] prd_r;

  always_ff @(posedge clk) begin
    if (load_acc && (int'(in_point_index) < MAX_POINTS)) begin
      pstore_mem[IDX_W'(in_point_index)] <= {in_point_x, in_point_y, in_point_z};
    end
    prd_r <= pstore_mem[k_r];
  end

  logic signed [COORD_W-1:0] px, py, pz;
  assign px = prd_r[3*COORD_W-1:2*COORD_W];
  assign py = prd_r[2*COORD_W-1:COORD_W];
  assign pz = prd_r[COORD_W-1:0];

  // ---------------------------------------------------------------------------
  // shared multiplier, product registered
  // ---------------------------------------------------------------------------
  logic [T_W-1:0]    t_r, u_r;
  logic [Q30_W-1:0]  tcur_r, ucur_r, w_r, bl_r;
  logic [Q30_W-1:0]  tp_r [MAX_POINTS];
  logic [Q30_W-1:0]  up_r [MAX_POINTS];
  logic [BIN_W-1:0]  binom_r [MAX_POINTS];

  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] prod_r;
  logic [63:0]        prod_u;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      ST_POWT: begin
        mul_a = {1'b0, tcur_r};
        mul_b = 32'(t_r);
      end
      ST_POWU: begin
        mul_a = {1'b0, ucur_r};
        mul_b = 32'(u_r);
      end
      ST_WGT: begin
        mul_a = {1'b0, tp_r[k_r]};
        mul_b = {1'b0, up_r[nk_r]};
      end
      ST_BIN: begin
        mul_a = 32'(binom_r[k_r]);
        mul_b = {1'b0, w_r};
      end
      ST_MX: begin
        mul_a = 32'(px);
        mul_b = {1'b0, bl_r};
      end
      ST_MY: begin
        mul_a = 32'(py);
        mul_b = {1'b0, bl_r};
      end
      ST_MZ: begin
        mul_a = 32'(pz);
        mul_b = {1'b0, bl_r};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
  end

  assign prod_u = prod_r;

  // Q16 power step and Q30 weight, both rounded half up
  logic [46:0]      pow_sum;
  logic [Q30_W-1:0] pow_rnd;
  logic [60:0]      w_sum;

  assign pow_sum = prod_u[46:0] + 47'd32768;
  assign pow_rnd = pow_sum[46:16];
  assign w_sum   = prod_u[60:0] + 61'(1 << 29);

  // ---------------------------------------------------------------------------
  // datapath registers
  // ---------------------------------------------------------------------------
  logic signed [ACC_W-1:0] acc_r [3];
  logic [ACC_W-1:0]        mag_r [3];
  logic                    neg_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r       <= '0;
      nk_r      <= '0;
      n_r       <= '0;
      pas_cnt_r <= '0;
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (eval_acc) begin
            n_r       <= n_c;
            pas_cnt_r <= n_c;
          end
        end
        ST_PREP: begin
          if (pas_cnt_r != '0) begin
            pas_cnt_r <= pas_cnt_r - IDX_W'(1);
          end
          if (!div_busy && (pas_cnt_r == '0)) begin
            k_r  <= (n_r == '0) ? '0 : IDX_W'(1);
            nk_r <= n_r;
          end
        end
        ST_POWR: begin
          k_r <= (k_r == n_r) ? '0 : k_r + IDX_W'(1);
        end
        ST_ACCZ: begin
          if (k_r != n_r) begin
            k_r  <= k_r + IDX_W'(1);
            nk_r <= nk_r - IDX_W'(1);
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        if (eval_acc) begin
          binom_r[0] <= BIN_W'(1);
          for (int j = 1; j < MAX_POINTS; j++) begin
            binom_r[j] <= '0;
          end
          for (int l = 0; l < 3; l++) begin
            acc_r[l] <= '0;
          end
        end
      end
      ST_PREP: begin
        // one Pascal row a cycle, all entries at once
        if (pas_cnt_r != '0) begin
          for (int j = 1; j < MAX_POINTS; j++) begin
            binom_r[j] <= binom_r[j] + binom_r[j-1];
          end
        end
        if (!div_busy && (pas_cnt_r == '0)) begin
          t_r    <= div_t;
          u_r    <= T_ONE - div_t;
          tcur_r <= ONE_Q30;
          ucur_r <= ONE_Q30;
          tp_r[0] <= ONE_Q30;
          up_r[0] <= ONE_Q30;
        end
      end
      ST_POWU: begin
        tcur_r    <= pow_rnd;
        tp_r[k_r] <= pow_rnd;
      end
      ST_POWR: begin
        ucur_r    <= pow_rnd;
        up_r[k_r] <= pow_rnd;
      end
      ST_WRND: w_r <= w_sum[60:30];
      ST_BSAT: bl_r <= (prod_u > 64'(ONE_Q30)) ? ONE_Q30 : prod_u[Q30_W-1:0];
      ST_MY:   acc_r[LANE_X] <= acc_r[LANE_X] + ACC_W'(prod_r);
      ST_MZ:   acc_r[LANE_Y] <= acc_r[LANE_Y] + ACC_W'(prod_r);
      ST_ACCZ: acc_r[LANE_Z] <= acc_r[LANE_Z] + ACC_W'(prod_r);
      ST_FIN: begin
        for (int l = 0; l < 3; l++) begin
          neg_r[l] <= acc_r[l][ACC_W-1];
          mag_r[l] <= acc_r[l][ACC_W-1] ? ACC_W'(-acc_r[l]) : ACC_W'(acc_r[l]);
        end
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------------
  // drop 30 fraction bits, half away from zero, saturate to 24 bits
  // ---------------------------------------------------------------------------
  function automatic logic [COORD_W-1:0] sat_round(input logic [ACC_W-1:0] mag,
                                                    input logic neg);
    logic [SUM_W-1:0] sum;
    logic [RND_W-1:0] r;
    logic [RND_W-1:0] nr;
    logic [COORD_W-1:0] res;
    sum = {1'b0, mag} + SUM_W'(1 << 29);
    r   = sum[ACC_W:30];
    nr  = RND_W'(0) - r;
    if (neg) begin
      res = (r > RND_W'(COORD_NEG_LIM)) ? COORD_MIN_V : nr[COORD_W-1:0];
    end else begin
      res = (r > RND_W'(COORD_POS_LIM)) ? COORD_MAX_V : r[COORD_W-1:0];
    end
    return res;
  endfunction

  logic [COORD_W-1:0] cx_r, cy_r, cz_r;

  always_ff @(posedge clk) begin
    if (out_load) begin
      cx_r <= sat_round(mag_r[LANE_X], neg_r[LANE_X]);
      cy_r <= sat_round(mag_r[LANE_Y], neg_r[LANE_Y]);
      cz_r <= sat_round(mag_r[LANE_Z], neg_r[LANE_Z]);
    end
  end

  assign out_valid   = out_valid_r;
  assign out_curve_x = cx_r;
  assign out_curve_y = cy_r;
  assign out_curve_z = cz_r;

endmodule

// ===== hw/rtl/bce_checker.sv =====
// Port-level checks for bezier_curve_evaluator_unit, attached by bind.
// Depends on bce_pkg.
module bce_checker import bce_pkg::*; (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_valid,
  input logic                      in_ready,
  input logic                      in_action,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic signed [COORD_W-1:0] out_curve_x,
  input logic signed [COORD_W-1:0] out_curve_y,
  input logic signed [COORD_W-1:0] out_curve_z
);

  // a waiting result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_curve_x) &&
                                $stable(out_curve_y) && $stable(out_curve_z))
    else $error("result beat changed while stalled");

  // an evaluate beat makes the block busy on the next cycle
  a_eval_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_action == ACTION_EVAL) |=> !in_ready)
    else $error("input still ready after evaluate beat");

  // a load beat leaves the block ready
  a_load_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_action == ACTION_LOAD) |=> in_ready)
    else $error("load beat made the block busy");

  // a result only appears at the end of an evaluation
  a_out_from_eval: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared while idle");

  // reset leaves the block empty and ready
  a_reset_state: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("bad state after reset");

endmodule

bind bezier_curve_evaluator_unit bce_checker u_bce_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .in_action   (in_action),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .out_curve_x (out_curve_x),
  .out_curve_y (out_curve_y),
  .out_curve_z (out_curve_z)
);
